/* design/stun_pkg.sv */
`timescale 1ns / 1ps

package stun_pkg;

   localparam int STUN_MAX_CHARS = 4096;
   localparam int CHAR_W         = 8;
   localparam int BASE_W         = 6;
   localparam int VALUE_W        = 32;
   localparam int INDEX_W        = 13;

   localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
   localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CH_CR    = 8'h0d;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
   localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2b;
   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
   localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
   localparam logic [CHAR_W-1:0] CH_UPPER_X = 8'h58;
   localparam logic [CHAR_W-1:0] CH_LOWER_X = 8'h78;
   localparam logic [CHAR_W-1:0] DIGIT_NONE = 8'hff;

   localparam logic [BASE_W-1:0] BASE_AUTO = 6'd0;
   localparam logic [BASE_W-1:0] BASE_OCT  = 6'd8;
   localparam logic [BASE_W-1:0] BASE_DEC  = 6'd10;
   localparam logic [BASE_W-1:0] BASE_HEX  = 6'd16;

   typedef enum logic [2:0] {
      PH_SPACE      = 3'd0,
      PH_MINUS      = 3'd1,
      PH_PLUS       = 3'd2,
      PH_PREFIX     = 3'd3,
      PH_AFTER_ZERO = 3'd4,
      PH_DIGITS     = 3'd5,
      PH_DONE       = 3'd6
   } phase_type;

   typedef struct packed {
      logic [VALUE_W-1:0] sum;
      logic               overflow;
   } mac_result_type;

   // digit value of a byte, wrapping modulo 256; DIGIT_NONE for the bytes between '9' and 'A'
   function automatic logic [CHAR_W-1:0] digit_of(input logic [CHAR_W-1:0] ch);
      logic [CHAR_W-1:0] d;
      if (ch >= CH_LOWER_A) begin
         d = ch - CH_LOWER_A + 8'd10;
      end else if (ch >= CH_UPPER_A) begin
         d = ch - CH_UPPER_A + 8'd10;
      end else if (ch <= CH_NINE) begin
         d = ch - CH_ZERO;
      end else begin
         d = DIGIT_NONE;
      end
      return d;
   endfunction

   function automatic logic is_space(input logic [CHAR_W-1:0] ch);
      return ((ch >= CH_TAB) && (ch <= CH_CR)) || (ch == CH_SPACE);
   endfunction

endpackage

/* design/stun_if.sv */
`timescale 1ns / 1ps

interface stun_req_if
   import stun_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] character;
   logic              last;

   modport source (output valid, output character, output last, input ready);
   modport sink   (input valid, input character, input last, output ready);
endinterface

interface stun_rsp_if
   import stun_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [VALUE_W-1:0] value;
   logic [INDEX_W-1:0] end_index;
   logic               overflowed;

   modport source (output valid, output value, output end_index, output overflowed,
                   input ready);
   modport sink   (input valid, input value, input end_index, input overflowed,
                   output ready);
endinterface

/* design/string_to_unsigned_parser.sv */
`timescale 1ns / 1ps
// the result is registered: it reaches the output register in the cycle after the
// last character is accepted; throughput: one character per cycle while the output
// register is empty or being read, set by the single 32x6 multiply-add per digit
// reset: synchronous, clears the parse state, the result valid flag and number_base

module string_to_unsigned_parser
   import stun_pkg::*;
#(
   parameter int MAX_CHARS = STUN_MAX_CHARS
) (
   input  logic              clock,
   input  logic              reset,
   stun_req_if.sink          req_bus,
   stun_rsp_if.source        rsp_bus,
   input  logic              csr_wr_en,
   input  logic [BASE_W-1:0] csr_wr_data
);

   localparam int POS_W = $clog2(MAX_CHARS + 1);
   localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_CHARS);

   logic [BASE_W-1:0]  number_base_ff;
   phase_type          phase_ff, phase_in;
   logic [VALUE_W-1:0] acc_ff, acc_in;
   logic               minus_ff, minus_in;
   logic [BASE_W-1:0]  wbase_ff, wbase_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [POS_W-1:0]   stop_ff, stop_in;
   logic               ovf_ff, ovf_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic [INDEX_W-1:0] index_ff, index_in;
   logic               overflowed_ff, overflowed_in;

   logic               accept;
   logic [CHAR_W-1:0]  ch;
   logic [CHAR_W-1:0]  digit;
   logic [BASE_W-1:0]  prefix_base;
   logic [BASE_W-1:0]  mac_base;
   mac_result_type     mac_res;
   logic [POS_W+INDEX_W-1:0] pos_wide;

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign accept        = req_bus.valid && req_bus.ready;
   assign ch            = req_bus.character;
   assign digit         = digit_of(ch);

   // base in force when digits start straight from the prefix check
   assign prefix_base = (number_base_ff == BASE_AUTO) ? BASE_DEC : number_base_ff;
   assign mac_base    = ((phase_ff == PH_AFTER_ZERO) || (phase_ff == PH_DIGITS)) ?
                        wbase_ff : prefix_base;

   stun_mac u_mac (
      .acc    (acc_ff),
      .base   (mac_base),
      .digit  (digit),
      .result (mac_res)
   );

   always_comb begin
      phase_type ph;
      logic      handled;
      logic      adv;
      logic [VALUE_W-1:0] v;
      logic [POS_W-1:0]   p;

      ph       = phase_ff;
      handled  = 1'b0;
      adv      = 1'b0;
      acc_in   = acc_ff;
      minus_in = minus_ff;
      wbase_in = wbase_ff;
      stop_in  = stop_ff;
      ovf_in   = ovf_ff;

      if (ph == PH_SPACE) begin
         if (is_space(ch)) begin
            adv     = 1'b1;
            handled = 1'b1;
         end else begin
            ph = PH_MINUS;
         end
      end
      if (!handled && ph == PH_MINUS) begin
         ph = PH_PLUS;
         if (ch == CH_MINUS) begin
            minus_in = 1'b1;
            adv      = 1'b1;
            handled  = 1'b1;
         end
      end
      if (!handled && ph == PH_PLUS) begin
         ph = PH_PREFIX;
         if (ch == CH_PLUS) begin
            adv     = 1'b1;
            handled = 1'b1;
         end
      end
      if (!handled && ph == PH_PREFIX) begin
         if (((number_base_ff == BASE_AUTO) || (number_base_ff == BASE_HEX)) &&
             (ch == CH_ZERO)) begin
            wbase_in = (number_base_ff == BASE_AUTO) ? BASE_OCT : number_base_ff;
            acc_in   = '0;
            adv      = 1'b1;
            ph       = PH_AFTER_ZERO;
            handled  = 1'b1;
         end else begin
            wbase_in = prefix_base;
            ph       = PH_DIGITS;
         end
      end else if (!handled && ph == PH_AFTER_ZERO) begin
         ph = PH_DIGITS;
         if ((ch == CH_LOWER_X) || (ch == CH_UPPER_X)) begin
            wbase_in = BASE_HEX;
            adv      = 1'b1;
            handled  = 1'b1;
         end
      end
      if (!handled && ph == PH_DIGITS) begin
         if ((ch == CH_NUL) || (digit >= CHAR_W'(mac_base))) begin
            stop_in = pos_ff;
            ph      = PH_DONE;
         end else begin
            if (!ovf_ff) begin
               acc_in = mac_res.sum;
               ovf_in = mac_res.overflow;
            end
            adv = 1'b1;
         end
      end

      pos_in = (adv && (pos_ff < POS_MAX)) ? pos_ff + 1'b1 : pos_ff;

      // result from the updated state
      if (ovf_in) begin
         v = '1;
      end else if (minus_in) begin
         v = '0 - acc_in;
      end else begin
         v = acc_in;
      end
      p        = (ph == PH_DONE) ? stop_in : pos_in;
      pos_wide = {INDEX_W'(0), p};
      value_in      = v;
      index_in      = pos_wide[INDEX_W-1:0];
      overflowed_in = ovf_in;
      phase_in      = ph;

      // the string is finished: start over for the next one
      if (req_bus.last) begin
         phase_in = PH_SPACE;
         acc_in   = '0;
         minus_in = 1'b0;
         wbase_in = '0;
         pos_in   = '0;
         stop_in  = '0;
         ovf_in   = 1'b0;
      end
   end

   always_comb begin
      if (accept && req_bus.last) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         number_base_ff <= '0;
         phase_ff       <= PH_SPACE;
         acc_ff         <= '0;
         minus_ff       <= 1'b0;
         wbase_ff       <= '0;
         pos_ff         <= '0;
         stop_ff        <= '0;
         ovf_ff         <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            number_base_ff <= csr_wr_data;
         end
         if (accept) begin
            phase_ff <= phase_in;
            acc_ff   <= acc_in;
            minus_ff <= minus_in;
            wbase_ff <= wbase_in;
            pos_ff   <= pos_in;
            stop_ff  <= stop_in;
            ovf_ff   <= ovf_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_bus.last) begin
         value_ff      <= value_in;
         index_ff      <= index_in;
         overflowed_ff <= overflowed_in;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.value      = value_ff;
   assign rsp_bus.end_index  = index_ff;
   assign rsp_bus.overflowed = overflowed_ff;

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid_ff)
      else $error("output register not empty after reset");

   a_ovf_all_ones: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && overflowed_ff) |-> (value_ff == '1))
      else $error("overflowed result is not all ones");

   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      (accept && req_bus.last) |=> (phase_ff == PH_SPACE && acc_ff == '0 && pos_ff == '0))
      else $error("parse state not cleared after the last character");

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      (pos_ff <= POS_MAX) && (stop_ff <= POS_MAX))
      else $error("character position beyond its limit");

   a_ovf_acc: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> (acc_ff == '1))
      else $error("overflow flag set with accumulator not saturated");

endmodule

/* design/stun_mac.sv */
`timescale 1ns / 1ps

module stun_mac
   import stun_pkg::*;
(
   input  logic [VALUE_W-1:0] acc,
   input  logic [BASE_W-1:0]  base,
   input  logic [CHAR_W-1:0]  digit,
   output mac_result_type     result
);

   localparam int PROD_W = VALUE_W + BASE_W + 1;

   logic [PROD_W-1:0] full_sum;

   assign full_sum = PROD_W'(acc) * PROD_W'(base) + PROD_W'(digit);

   always_comb begin
      result.overflow = |full_sum[PROD_W-1:VALUE_W];
      result.sum      = result.overflow ? '1 : full_sum[VALUE_W-1:0];
   end

endmodule
